@@ rtl/core/fts_pkg.sv @@
// Shared types and constants for the fitness tournament selector.
// Depends on nothing; imported by the core and the checker.
`timescale 1ns / 1ps
`default_nettype none

package fts_pkg;

    // Fixed widths of the external fields
    localparam int CFG_W      = 7;
    localparam int IN_IDX_W   = 6;
    localparam int FIT_IN_W   = 24;
    localparam int DRAW_W     = 16;

    // Tournament and fixed-point constants
    localparam int TOURNAMENT_SIZE = 3;
    localparam int FIXED_ONE       = 256;
    localparam int CFG_RESET       = 64;

    // Item kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SELECT = 1'b1;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SUM   = 5'b00010,
        S_SPAN  = 5'b00100,
        S_SCALE = 5'b01000,
        S_WALK  = 5'b10000
    } fts_state_t;

endpackage

`default_nettype wire

@@ rtl/core/fts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module fts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire                             clk,
    input  wire                             we,
    input  wire  [$clog2(DEPTH)-1:0]        waddr,
    input  wire  [WIDTH-1:0]                wdata,
    input  wire  [$clog2(DEPTH)-1:0]        raddr,
    output logic [WIDTH-1:0]                rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/fitness_tournament_selector.sv @@
// Fitness tournament selector: fitness table in RAM, roulette walks, three-way tournament.
// Depends on fts_pkg and fts_ram.
// Load: taken in idle, no result; busy stays low.
// Select: with n entries in use, the single RAM read port bounds the work: one pass
// for the total (the only pass for a zero total), then one walk per draw that stops at
// the chosen entry. One item at a time.
// The result strobe lasts one cycle and the next item may be taken in that cycle.
// Reset clears the sequencer and sets entries_in_use to 64; table contents are undefined.
`timescale 1ns / 1ps
`default_nettype none

module fitness_tournament_selector #(
    parameter int MAX_ENTRIES  = 64,
    parameter int FITNESS_BITS = 24
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // command channel
    input  wire                              start,
    output logic                             busy,
    input  wire                              kind,
    input  wire  [fts_pkg::IN_IDX_W-1:0]     entry_index,
    input  wire  [fts_pkg::FIT_IN_W-1:0]     fitness_value,
    input  wire  [fts_pkg::DRAW_W-1:0]       draw_first,
    input  wire  [fts_pkg::DRAW_W-1:0]       draw_second,
    input  wire  [fts_pkg::DRAW_W-1:0]       draw_third,
    // configuration
    input  wire                              cfg_write_en,
    input  wire  [fts_pkg::CFG_W-1:0]        cfg_write_data,
    // result channel
    output logic                             result_valid,
    output logic [fts_pkg::IN_IDX_W-1:0]     winner_index,
    output logic [fts_pkg::FIT_IN_W-1:0]     winner_fitness,
    output logic                             total_was_zero
);

    import fts_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam int TOT_W  = FITNESS_BITS + ADDR_W;
    localparam int PROD_W = DRAW_W + TOT_W;
    localparam int K_W    = $clog2(TOURNAMENT_SIZE);

    // Control registers
    fts_state_t             state_reg, state_next;
    logic [CFG_W-1:0]       entries_reg;
    logic [ADDR_W-1:0]      last_idx_reg, last_idx_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic                   issue_reg, issue_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [ADDR_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [K_W-1:0]         k_reg, k_next;
    logic                   result_valid_reg, result_valid_next;

    // Datapath registers
    logic [DRAW_W-1:0]       draw_reg [TOURNAMENT_SIZE];
    logic [TOT_W-1:0]        total_reg, total_next;
    logic [TOT_W-1:0]        span_reg, span_next;
    logic [TOT_W-1:0]        target_reg, target_next;
    logic [TOT_W-1:0]        run_reg, run_next;
    logic [FITNESS_BITS-1:0] fit0_reg, fit0_next;
    logic [ADDR_W-1:0]       best_idx_reg, best_idx_next;
    logic [FITNESS_BITS-1:0] best_fit_reg, best_fit_next;
    logic [ADDR_W-1:0]       win_idx_reg, win_idx_next;
    logic [FITNESS_BITS-1:0] win_fit_reg, win_fit_next;
    logic                    zero_reg, zero_next;

    // Memory port signals
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [FITNESS_BITS-1:0] ram_wdata;
    logic [FITNESS_BITS-1:0] ram_rdata;

    // Helper values
    logic                    accept;
    logic [31:0]             load_idx32;
    logic [31:0]             load_fit32;
    logic [31:0]             entries32;
    logic [ADDR_W-1:0]       last_idx_calc;
    logic [TOT_W-1:0]        sum_val;
    logic [PROD_W-1:0]       product;
    logic                    hit;
    logic                    at_last;
    logic [ADDR_W-1:0]       pick_idx;
    logic [FITNESS_BITS-1:0] pick_fit;
    logic                    replace;
    logic [31:0]             win_idx32;
    logic [31:0]             win_fit32;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // Load path: write in the transfer cycle, drop indexes beyond the table
    assign load_idx32 = 32'(entry_index);
    assign load_fit32 = 32'(fitness_value);
    assign ram_we     = accept && (kind == KIND_LOAD) && (load_idx32 < MAX_ENTRIES);
    assign ram_waddr  = load_idx32[ADDR_W-1:0];
    assign ram_wdata  = load_fit32[FITNESS_BITS-1:0];

    // Clamp the entry count to 1..MAX_ENTRIES and keep the last index
    assign entries32 = 32'(entries_reg);
    always_comb
    begin
        if (entries32 >= MAX_ENTRIES)
        begin
            last_idx_calc = ADDR_W'(MAX_ENTRIES - 1);
        end
        else if (entries32 == 32'd0)
        begin
            last_idx_calc = '0;
        end
        else
        begin
            last_idx_calc = ADDR_W'(entries32 - 32'd1);
        end
    end

    fts_ram #(
        .WIDTH (FITNESS_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // Shared arithmetic: running sum, scaled target, walk decision
    assign sum_val  = (state_reg == S_SUM ? total_reg : run_reg) + TOT_W'(ram_rdata);
    assign product  = PROD_W'(draw_reg[k_reg]) * PROD_W'(span_reg);
    assign hit      = (sum_val >= target_reg);
    assign at_last  = (rd_idx_reg == last_idx_reg);
    assign pick_idx = hit ? rd_idx_reg : '0;
    assign pick_fit = hit ? ram_rdata : fit0_reg;
    assign replace  = (k_reg == '0) || (pick_fit > best_fit_reg);

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        last_idx_next     = last_idx_reg;
        addr_next         = addr_reg;
        issue_next        = issue_reg;
        rd_vld_next       = 1'b0;
        rd_idx_next       = addr_reg;
        k_next            = k_reg;
        result_valid_next = 1'b0;
        total_next        = total_reg;
        span_next         = span_reg;
        target_next       = target_reg;
        run_next          = run_reg;
        fit0_next         = fit0_reg;
        best_idx_next     = best_idx_reg;
        best_fit_next     = best_fit_reg;
        win_idx_next      = win_idx_reg;
        win_fit_next      = win_fit_reg;
        zero_next         = zero_reg;

        // Advance the read address while a pass is issuing
        if ((state_reg inside {S_SUM, S_WALK}) && issue_reg)
        begin
            rd_vld_next = 1'b1;
            addr_next   = addr_reg + ADDR_W'(1);
            if (addr_reg == last_idx_reg)
            begin
                issue_next = 1'b0;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (kind == KIND_SELECT))
                begin
                    state_next    = S_SUM;
                    last_idx_next = last_idx_calc;
                    addr_next     = '0;
                    issue_next    = 1'b1;
                    total_next    = '0;
                    k_next        = '0;
                end
            end

            S_SUM:
            begin
                if (rd_vld_reg)
                begin
                    total_next = sum_val;
                    if (rd_idx_reg == '0)
                    begin
                        fit0_next = ram_rdata;
                    end
                    if (at_last)
                    begin
                        rd_vld_next = 1'b0;
                        issue_next  = 1'b0;
                        if (sum_val == '0)
                        begin
                            // Zero total forces entry 0
                            state_next        = S_IDLE;
                            result_valid_next = 1'b1;
                            win_idx_next      = '0;
                            win_fit_next      = (rd_idx_reg == '0) ? ram_rdata : fit0_reg;
                            zero_next         = 1'b1;
                        end
                        else
                        begin
                            state_next = S_SPAN;
                        end
                    end
                end
            end

            S_SPAN:
            begin
                // Span is total minus one, clamped at zero
                if (total_reg > TOT_W'(FIXED_ONE))
                begin
                    span_next = total_reg - TOT_W'(FIXED_ONE);
                end
                else
                begin
                    span_next = '0;
                end
                state_next = S_SCALE;
            end

            S_SCALE:
            begin
                target_next = product[DRAW_W +: TOT_W];
                run_next    = '0;
                addr_next   = '0;
                issue_next  = 1'b1;
                state_next  = S_WALK;
            end

            S_WALK:
            begin
                if (rd_vld_reg)
                begin
                    run_next = sum_val;
                    if (hit || at_last)
                    begin
                        rd_vld_next = 1'b0;
                        issue_next  = 1'b0;
                        if (replace)
                        begin
                            best_idx_next = pick_idx;
                            best_fit_next = pick_fit;
                        end
                        if (k_reg == K_W'(TOURNAMENT_SIZE - 1))
                        begin
                            state_next        = S_IDLE;
                            result_valid_next = 1'b1;
                            win_idx_next      = replace ? pick_idx : best_idx_reg;
                            win_fit_next      = replace ? pick_fit : best_fit_reg;
                            zero_next         = 1'b0;
                        end
                        else
                        begin
                            k_next     = k_reg + K_W'(1);
                            state_next = S_SCALE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            entries_reg      <= CFG_W'(CFG_RESET);
            last_idx_reg     <= '0;
            addr_reg         <= '0;
            issue_reg        <= 1'b0;
            rd_vld_reg       <= 1'b0;
            rd_idx_reg       <= '0;
            k_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            last_idx_reg     <= last_idx_next;
            addr_reg         <= addr_next;
            issue_reg        <= issue_next;
            rd_vld_reg       <= rd_vld_next;
            rd_idx_reg       <= rd_idx_next;
            k_reg            <= k_next;
            result_valid_reg <= result_valid_next;
            if (cfg_write_en)
            begin
                entries_reg <= cfg_write_data;
            end
        end
    end

    // Payload: hold the draws of the item taken and the datapath values
    always_ff @(posedge clk)
    begin
        if (accept && (kind == KIND_SELECT))
        begin
            draw_reg[0] <= draw_first;
            draw_reg[1] <= draw_second;
            draw_reg[2] <= draw_third;
        end
        total_reg    <= total_next;
        span_reg     <= span_next;
        target_reg   <= target_next;
        run_reg      <= run_next;
        fit0_reg     <= fit0_next;
        best_idx_reg <= best_idx_next;
        best_fit_reg <= best_fit_next;
        win_idx_reg  <= win_idx_next;
        win_fit_reg  <= win_fit_next;
        zero_reg     <= zero_next;
    end

    // Result ports
    assign win_idx32      = 32'(win_idx_reg);
    assign win_fit32      = 32'(win_fit_reg);
    assign result_valid   = result_valid_reg;
    assign winner_index   = win_idx32[IN_IDX_W-1:0];
    assign winner_fitness = win_fit32[FIT_IN_W-1:0];
    assign total_was_zero = zero_reg;

endmodule

`default_nettype wire

@@ rtl/core/fts_checker.sv @@
// Port-level checker for the fitness tournament selector, with its bind.
// Depends on fts_pkg; attaches to fitness_tournament_selector.
`timescale 1ns / 1ps
`default_nettype none

module fts_checker (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire                          busy,
    input  wire                          kind,
    input  wire                          result_valid,
    input  wire  [fts_pkg::IN_IDX_W-1:0] winner_index,
    input  wire                          total_was_zero
);

    import fts_pkg::*;

    // A result never shows while a selection is still in work
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while busy");

    // A selection transfer makes the block busy
    a_select_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_SELECT) |=> busy)
        else $error("select not taken into work");

    // A load transfer leaves the block free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_LOAD) |=> (!busy && !result_valid))
        else $error("load caused work or a result");

    // Results are single-cycle strobes
    a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held");

    // A zero total forces entry 0
    a_zero_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && total_was_zero) |-> (winner_index == '0))
        else $error("zero total without entry 0");

endmodule

bind fitness_tournament_selector fts_checker u_fts_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .result_valid   (result_valid),
    .winner_index   (winner_index),
    .total_was_zero (total_was_zero)
);

`default_nettype wire
